### src/assert_macros.svh
// Assertion macros shared by the barometric compensation RTL.
// No dependencies; SYNTHESIS selects the empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock edge, disabled while reset is active.
`define BSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsc assertion failed");
// Check a property on the rising clock edge, also during reset.
`define BSC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bsc reset assertion failed");
`else
`define BSC_ASSERT(lbl, clk, rst_n, prop)
`define BSC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

### src/bsc_pkg.sv
// Shared widths, constants, register codes and stage payload types for the
// barometric compensation pipeline. No dependencies.
package bsc_pkg;

  // Port widths
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TEMP_W    = 15;
  localparam int PRESS_W   = 17;

  // Internal widths
  localparam int DT_W    = 25;  // raw temperature minus reference
  localparam int PROD_W  = 42;  // dT times a calibration word
  localparam int DSQ_W   = 50;  // dT squared
  localparam int DTEMP_W = 19;  // TEMP - 2000
  localparam int TEMP1_W = 20;  // first order TEMP
  localparam int DTP_W   = 20;  // TEMP + 1500
  localparam int T2_W    = 18;
  localparam int OFF_W   = 37;
  localparam int SENS_W  = 36;
  localparam int SQ1_W   = 38;
  localparam int SQ2_W   = 40;
  localparam int TERM_W  = 42;  // second order correction terms
  localparam int FIN_W   = 42;  // corrected OFF
  localparam int SENSM_W = 39;  // corrected SENS, as it enters the multiplier
  localparam int SLO_W   = 20;  // low unsigned slice of SENS
  localparam int SHI_W   = SENSM_W - SLO_W;
  localparam int PP_W    = 44;
  localparam int P64_W   = 64;
  localparam int X_W     = 44;
  localparam int P_W     = 29;
  localparam int TEMPF_W = 21;

  // Scaling and limits
  localparam int signed TEMP_REF     = 2000;
  localparam int signed TEMP_LOW_OFS = 3500;   // 2000 - (-1500)
  localparam int signed TEMP_MIN     = -4000;
  localparam int signed TEMP_MAX     = 8500;
  localparam int signed PRESS_MIN    = 1000;
  localparam int signed PRESS_MAX    = 120000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coef_t;

  // First order results plus squares for the second order correction
  typedef struct packed {
    logic signed [SQ1_W-1:0]   sq1;
    logic signed [SQ2_W-1:0]   sq2;
    logic                      lt_ref;
    logic                      lt_low;
    logic signed [TEMPF_W-1:0] temp_f;
    logic signed [OFF_W-1:0]   off;
    logic signed [SENS_W-1:0]  sens;
    logic [RAW_W-1:0]          d1;
  } fo_t;

  // Corrected offset and sensitivity
  typedef struct packed {
    logic signed [FIN_W-1:0]   off_f;
    logic signed [SENSM_W-1:0] sens_f;
    logic signed [TEMPF_W-1:0] temp_f;
    logic [RAW_W-1:0]          d1;
  } so_t;

endpackage

### src/baro_sensor_compensation.sv
// Top level of the barometric pressure compensation pipeline.
// Depends on bsc_pkg, bsc_cfg_regs, bsc_front, bsc_second, bsc_press and assert_macros.svh.
//
// Usage:
//   Input channel in_*: one item carries a raw temperature (D2) and a raw
//   pressure (D1) conversion; it is taken when in_valid is high and in_stall
//   low. Result channel out_*: one item per input, temperature in 0.01 C,
//   pressure in 0.01 mbar, and a flag set when either value was saturated.
//   Config channel cfg_*: six calibration words C1..C6 at indexes 0..5,
//   written when cfg_valid and cfg_ready are high; cfg_ready is always high
//   and other indexes are ignored. Write them only while the pipe is empty.
//   Throughput: one item per cycle while out_stall does not hold the pipe; the
//   nine register stages hold one item each, set by the split 24 x 39 bit
//   pressure multiply and the squaring stages.
//   Stall: while the output register holds an item and out_stall is high,
//   the whole pipe freezes and in_stall is raised; nothing is dropped.
//   Reset: synchronous, active low; clears all stage valid bits and sets
//   the calibration words to zero.
`include "assert_macros.svh"
module baro_sensor_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bsc_pkg::RAW_W-1:0]           in_raw_temperature,
  input  logic [bsc_pkg::RAW_W-1:0]           in_raw_pressure,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bsc_pkg::TEMP_W-1:0]   out_temp_centi,
  output logic [bsc_pkg::PRESS_W-1:0]         out_press_centi,
  output logic                                out_clamped,
  // calibration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsc_pkg::COEF_W-1:0]          cfg_data
);
  import bsc_pkg::*;

  coef_t coef;
  logic  adv;
  logic  fo_v, so_v;
  fo_t   fo;
  so_t   so;

  // Advance every stage unless the finished item is held by the receiver.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  bsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // First order: dT, TEMP, OFF, SENS, T2 and the correction squares.
  bsc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (in_valid),
    .d2    (in_raw_temperature),
    .d1    (in_raw_pressure),
    .coef  (coef),
    .out_v (fo_v),
    .fo    (fo)
  );

  // Second order: subtract OFF2 and SENS2 below 20 C and -15 C.
  bsc_second u_second (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (fo_v),
    .fo    (fo),
    .out_v (so_v),
    .so    (so)
  );

  // Pressure product, scaling, saturation and the output register.
  bsc_press u_press (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_v            (so_v),
    .so              (so),
    .out_valid       (out_valid),
    .out_temp_centi  (out_temp_centi),
    .out_press_centi (out_press_centi),
    .out_clamped     (out_clamped)
  );

  `BSC_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

### src/bsc_cfg_regs.sv
// Calibration word register file for the barometric compensation block.
// Depends on bsc_pkg.
module bsc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsc_pkg::COEF_W-1:0]     cfg_data,
  output bsc_pkg::coef_t                 coef
);
  import bsc_pkg::*;

  coef_t coef_r;

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_C1:  coef_r.c1 <= cfg_data;
        CFG_C2:  coef_r.c2 <= cfg_data;
        CFG_C3:  coef_r.c3 <= cfg_data;
        CFG_C4:  coef_r.c4 <= cfg_data;
        CFG_C5:  coef_r.c5 <= cfg_data;
        CFG_C6:  coef_r.c6 <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

### src/bsc_front.sv
// Stages 1-4: temperature difference, first order TEMP/OFF/SENS, squares.
// Depends on bsc_pkg.
module bsc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_v,
  input  logic [bsc_pkg::RAW_W-1:0]  d2,
  input  logic [bsc_pkg::RAW_W-1:0]  d1,
  input  bsc_pkg::coef_t             coef,
  output logic                       out_v,
  output bsc_pkg::fo_t               fo
);
  import bsc_pkg::*;

  // stage 1
  logic                      v1_r;
  logic signed [DT_W-1:0]    dt_nxt, dt_r;
  logic [RAW_W-1:0]          d1_1_r;
  // stage 2
  logic                      v2_r;
  logic signed [PROD_W-1:0]  prod_t_nxt, prod_t_r;
  logic signed [PROD_W-1:0]  prod_o_nxt, prod_o_r;
  logic signed [PROD_W-1:0]  prod_s_nxt, prod_s_r;
  logic signed [DSQ_W-1:0]   dtsq_nxt, dtsq_r;
  logic [RAW_W-1:0]          d1_2_r;
  // stage 3
  logic                      v3_r;
  logic signed [DTEMP_W-1:0] dtemp_nxt, dtemp_r;
  logic signed [DTP_W-1:0]   dtp_nxt, dtp_r;
  logic signed [TEMP1_W-1:0] temp1_nxt, temp1_r;
  logic signed [OFF_W-1:0]   off_nxt, off_r;
  logic signed [SENS_W-1:0]  sens_nxt, sens_r;
  logic [T2_W-1:0]           t2_nxt, t2_r;
  logic [RAW_W-1:0]          d1_3_r;
  // stage 4
  logic                      v4_r;
  fo_t                       fo_nxt, fo_r;

  // dT = D2 - C5 * 2^8
  assign dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, coef.c5, 8'h00});

  // the four products of dT
  assign prod_t_nxt = PROD_W'(dt_r) * PROD_W'($signed({1'b0, coef.c6}));
  assign prod_o_nxt = PROD_W'(dt_r) * PROD_W'($signed({1'b0, coef.c4}));
  assign prod_s_nxt = PROD_W'(dt_r) * PROD_W'($signed({1'b0, coef.c3}));
  assign dtsq_nxt   = DSQ_W'(dt_r) * DSQ_W'(dt_r);

  // floor shifts are arithmetic part-selects of the signed products
  assign dtemp_nxt = $signed(prod_t_r[PROD_W-1:23]);
  assign temp1_nxt = TEMP1_W'(dtemp_nxt) + TEMP1_W'(TEMP_REF);
  assign dtp_nxt   = DTP_W'(dtemp_nxt) + DTP_W'(TEMP_LOW_OFS);
  assign off_nxt   = OFF_W'($signed({1'b0, coef.c2, 16'h0000}))
                   + OFF_W'($signed(prod_o_r[PROD_W-1:7]));
  assign sens_nxt  = SENS_W'($signed({1'b0, coef.c1, 15'h0000}))
                   + SENS_W'($signed(prod_s_r[PROD_W-1:8]));
  assign t2_nxt    = dtsq_r[T2_W+30:31];

  always_comb begin
    fo_nxt        = '0;
    fo_nxt.sq1    = SQ1_W'(dtemp_r) * SQ1_W'(dtemp_r);
    fo_nxt.sq2    = SQ2_W'(dtp_r) * SQ2_W'(dtp_r);
    fo_nxt.lt_ref = dtemp_r[DTEMP_W-1];
    fo_nxt.lt_low = dtp_r[DTP_W-1];
    fo_nxt.off    = off_r;
    fo_nxt.sens   = sens_r;
    fo_nxt.d1     = d1_3_r;
    if (dtemp_r[DTEMP_W-1]) begin
      fo_nxt.temp_f = TEMPF_W'(temp1_r) - TEMPF_W'($signed({1'b0, t2_r}));
    end else begin
      fo_nxt.temp_f = TEMPF_W'(temp1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dt_r     <= dt_nxt;
      d1_1_r   <= d1;
      prod_t_r <= prod_t_nxt;
      prod_o_r <= prod_o_nxt;
      prod_s_r <= prod_s_nxt;
      dtsq_r   <= dtsq_nxt;
      d1_2_r   <= d1_1_r;
      dtemp_r  <= dtemp_nxt;
      dtp_r    <= dtp_nxt;
      temp1_r  <= temp1_nxt;
      off_r    <= off_nxt;
      sens_r   <= sens_nxt;
      t2_r     <= t2_nxt;
      d1_3_r   <= d1_2_r;
      fo_r     <= fo_nxt;
    end
  end

  assign out_v = v4_r;
  assign fo    = fo_r;

endmodule

### src/bsc_second.sv
// Stages 5-6: second order OFF2/SENS2 terms and their subtraction.
// Depends on bsc_pkg.
module bsc_second (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_v,
  input  bsc_pkg::fo_t  fo,
  output logic          out_v,
  output bsc_pkg::so_t  so
);
  import bsc_pkg::*;

  logic                      v5_r, v6_r;
  logic signed [TERM_W-1:0]  s1, s2, five1, seven2, eleven2;
  logic signed [TERM_W-1:0]  off2_nxt, off2_r;
  logic signed [TERM_W-1:0]  sens2_nxt, sens2_r;
  logic signed [OFF_W-1:0]   off_r;
  logic signed [SENS_W-1:0]  sens_r;
  logic signed [TEMPF_W-1:0] temp_f_r;
  logic [RAW_W-1:0]          d1_r;
  logic signed [FIN_W-1:0]   sens_full;
  so_t                       so_nxt, so_r;

  // constant multiples by shift and add
  assign s1      = TERM_W'(fo.sq1);
  assign s2      = TERM_W'(fo.sq2);
  assign five1   = (s1 <<< 2) + s1;
  assign seven2  = (s2 <<< 3) - s2;
  assign eleven2 = (s2 <<< 3) + (s2 <<< 1) + s2;

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (fo.lt_ref) begin
      off2_nxt  = five1 >>> 1;
      sens2_nxt = five1 >>> 2;
      if (fo.lt_low) begin
        off2_nxt  = (five1 >>> 1) + seven2;
        sens2_nxt = (five1 >>> 2) + (eleven2 >>> 1);
      end
    end
  end

  assign sens_full = FIN_W'(sens_r) - FIN_W'(sens2_r);

  always_comb begin
    so_nxt        = '0;
    so_nxt.off_f  = FIN_W'(off_r) - FIN_W'(off2_r);
    so_nxt.sens_f = SENSM_W'(sens_full);
    so_nxt.temp_f = temp_f_r;
    so_nxt.d1     = d1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v5_r <= in_v;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      off2_r   <= off2_nxt;
      sens2_r  <= sens2_nxt;
      off_r    <= fo.off;
      sens_r   <= fo.sens;
      temp_f_r <= fo.temp_f;
      d1_r     <= fo.d1;
      so_r     <= so_nxt;
    end
  end

  assign out_v = v6_r;
  assign so    = so_r;

endmodule

### src/bsc_press.sv
// Stages 7-9: split D1*SENS product, pressure scaling, saturation, output.
// Depends on bsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bsc_press (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_v,
  input  bsc_pkg::so_t                        so,
  output logic                                out_valid,
  output logic signed [bsc_pkg::TEMP_W-1:0]   out_temp_centi,
  output logic [bsc_pkg::PRESS_W-1:0]         out_press_centi,
  output logic                                out_clamped
);
  import bsc_pkg::*;

  logic                      v7_r, v8_r, v9_r;
  // stage 7
  logic [PP_W-1:0]           pp_lo_nxt, pp_lo_r;
  logic signed [PP_W-1:0]    pp_hi_nxt, pp_hi_r;
  logic signed [FIN_W-1:0]   off_f_r;
  logic signed [TEMPF_W-1:0] temp_f_r;
  // stage 8
  logic signed [P64_W-1:0]   prod;
  logic signed [X_W-1:0]     x_nxt, x_r;
  logic signed [TEMP_W-1:0]  temp_sat_nxt, temp_sat_r;
  logic                      tclamp_nxt, tclamp_r;
  // stage 9
  logic signed [P_W-1:0]     pv;
  logic [PRESS_W-1:0]        press_nxt, press_r;
  logic                      clamp_nxt, clamp_r;
  logic signed [TEMP_W-1:0]  temp_out_r;

  // D1 * SENS as two partial products over a low unsigned and high signed slice
  assign pp_lo_nxt = PP_W'(so.d1) * PP_W'(so.sens_f[SLO_W-1:0]);
  assign pp_hi_nxt = PP_W'($signed({1'b0, so.d1}))
                   * PP_W'($signed(so.sens_f[SENSM_W-1:SLO_W]));

  assign prod  = (P64_W'(pp_hi_r) <<< SLO_W) + P64_W'($signed({1'b0, pp_lo_r}));
  assign x_nxt = X_W'($signed(prod[P64_W-1:21])) - X_W'(off_f_r);

  always_comb begin
    temp_sat_nxt = TEMP_W'(temp_f_r);
    tclamp_nxt   = 1'b0;
    priority if (temp_f_r < TEMPF_W'(TEMP_MIN)) begin
      temp_sat_nxt = TEMP_W'(TEMP_MIN);
      tclamp_nxt   = 1'b1;
    end else if (temp_f_r > TEMPF_W'(TEMP_MAX)) begin
      temp_sat_nxt = TEMP_W'(TEMP_MAX);
      tclamp_nxt   = 1'b1;
    end else begin
      tclamp_nxt   = 1'b0;
    end
  end

  assign pv = $signed(x_r[X_W-1:15]);

  always_comb begin
    press_nxt = pv[PRESS_W-1:0];
    clamp_nxt = tclamp_r;
    priority if (pv < P_W'(PRESS_MIN)) begin
      press_nxt = PRESS_W'(PRESS_MIN);
      clamp_nxt = 1'b1;
    end else if (pv > P_W'(PRESS_MAX)) begin
      press_nxt = PRESS_W'(PRESS_MAX);
      clamp_nxt = 1'b1;
    end else begin
      clamp_nxt = tclamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (adv) begin
      v7_r <= in_v;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_lo_r    <= pp_lo_nxt;
      pp_hi_r    <= pp_hi_nxt;
      off_f_r    <= so.off_f;
      temp_f_r   <= so.temp_f;
      x_r        <= x_nxt;
      temp_sat_r <= temp_sat_nxt;
      tclamp_r   <= tclamp_nxt;
      press_r    <= press_nxt;
      clamp_r    <= clamp_nxt;
      temp_out_r <= temp_sat_r;
    end
  end

  assign out_valid       = v9_r;
  assign out_temp_centi  = temp_out_r;
  assign out_press_centi = press_r;
  assign out_clamped     = clamp_r;

  `BSC_ASSERT(a_stage_moves, clk, rst_n, v7_r && adv |=> v8_r)
  `BSC_ASSERT(a_stage_holds, clk, rst_n, !adv && v8_r |=> v8_r)
  `BSC_ASSERT(a_out_range, clk, rst_n, out_valid |-> (out_temp_centi >= TEMP_W'(TEMP_MIN)) && (out_temp_centi <= TEMP_W'(TEMP_MAX)) && (out_press_centi >= PRESS_W'(PRESS_MIN)) && (out_press_centi <= PRESS_W'(PRESS_MAX)))

endmodule

### tb/tb_baro_sensor_compensation.sv
`timescale 1ns / 1ps
// Self-checking bench for baro_sensor_compensation: raw conversion pairs under
// several calibration sets, each result checked against a bit-exact model.
// Depends on bsc_pkg and the baro_sensor_compensation RTL.
module tb_baro_sensor_compensation;
  import bsc_pkg::*;

  // Run shape
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no item moving on any channel
  localparam int DRAIN_CYCLES    = 20;    // tail after the last result
  localparam int MAX_REPORTS     = 10;
  localparam int ITEMS_EXTREME   = 150;   // random items per extreme calibration set
  localparam int RANDOM_SETS     = 8;
  localparam int ITEMS_PER_SET   = 160;

  localparam longint RAW_LIMIT   = (longint'(1) << RAW_W) - 1;
  localparam longint TEMP_SCALE  = 64'sd8388608;  // 2^23, dT*C6 scaling
  localparam int signed TEMP_LOW = TEMP_REF - TEMP_LOW_OFS;  // -15.00 C

  // Indexes past the six calibration words; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Typical factory calibration; D2 8569150 / D1 9085466 give 20.07 C, 1000.09 mbar
  localparam coef_t COEF_TYPICAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                     c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
  localparam logic [RAW_W-1:0] D2_TYPICAL = 24'd8569150;
  localparam logic [RAW_W-1:0] D1_TYPICAL = 24'd9085466;
  localparam logic [RAW_W-1:0] D1_MID     = 24'd8388608;

  localparam coef_t EXTREME_SETS [3] = '{
    '{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF, c4: 16'hFFFF, c5: 16'hFFFF, c6: 16'hFFFF},
    '{c1: 16'h0000, c2: 16'hFFFF, c3: 16'hFFFF, c4: 16'h0000, c5: 16'h0000, c6: 16'hFFFF},
    '{c1: 16'hFFFF, c2: 16'h0000, c3: 16'h0000, c4: 16'hFFFF, c5: 16'hFFFF, c6: 16'h0001}
  };

  // Temperatures on both sides of each second-order threshold and each clamp
  localparam int signed DIRECTED_TEMPS [8] = '{TEMP_REF, TEMP_REF - 1, TEMP_LOW, TEMP_LOW - 1,
                                               TEMP_MIN, TEMP_MIN - 1, TEMP_MAX, TEMP_MAX + 1};

  typedef struct packed {
    logic [RAW_W-1:0] d2;
    logic [RAW_W-1:0] d1;
  } conversion_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    logic                     clamped;
  } reading_t;

  // DUT ports, every input known from time zero
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [RAW_W-1:0]           in_raw_temperature = '0;
  logic [RAW_W-1:0]           in_raw_pressure = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [TEMP_W-1:0]   out_temp_centi;
  logic [PRESS_W-1:0]         out_press_centi;
  logic                       out_clamped;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COEF_W-1:0]          cfg_data = '0;

  // Bench state
  conversion_t conversions_to_send[$];  // items waiting for the driver
  reading_t    readings_due[$];         // predicted results, oldest first
  coef_t       coef_shadow = '0;        // calibration as the DUT should hold it
  conversion_t next_conv;
  reading_t    got;
  reading_t    want;
  int in_gap = 0, in_burst = 0, out_hold = 0, out_burst = 0;
  int items_queued = 0, items_taken = 0, results_seen = 0, results_clamped = 0;
  int cal_sets = 0, mismatches = 0, idle_cycles = 0;

  baro_sensor_compensation i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_temp_centi     (out_temp_centi),
    .out_press_centi    (out_press_centi),
    .out_clamped        (out_clamped),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Second-order compensation, all intermediates exact in 64 bits. Every
  // divide by 2^n is an arithmetic shift, so it rounds toward minus infinity.
  function automatic reading_t compensate(input coef_t k, input logic [RAW_W-1:0] d2,
                                          input logic [RAW_W-1:0] d1);
    longint dt, t, off, sens, t2, off2, sens2, sq, p;
    reading_t r;
    dt   = longint'(d2) - longint'(k.c5) * 256;
    t    = TEMP_REF + ((dt * longint'(k.c6)) >>> 23);
    off  = longint'(k.c2) * 65536 + ((longint'(k.c4) * dt) >>> 7);
    sens = longint'(k.c1) * 32768 + ((longint'(k.c3) * dt) >>> 8);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    // Cold correction is driven by the first-order temperature
    if (t < TEMP_REF) begin
      t2    = (dt * dt) >>> 31;
      sq    = (t - TEMP_REF) * (t - TEMP_REF);
      off2  = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (t < TEMP_LOW) begin
        sq    = (t - TEMP_LOW) * (t - TEMP_LOW);
        off2  += 7 * sq;
        sens2 += (11 * sq) >>> 1;
      end
    end
    t    -= t2;
    off  -= off2;
    sens -= sens2;
    p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    r.clamped = 1'b0;
    if (t < TEMP_MIN) begin
      t = TEMP_MIN;
      r.clamped = 1'b1;
    end
    if (t > TEMP_MAX) begin
      t = TEMP_MAX;
      r.clamped = 1'b1;
    end
    if (p < PRESS_MIN) begin
      p = PRESS_MIN;
      r.clamped = 1'b1;
    end
    if (p > PRESS_MAX) begin
      p = PRESS_MAX;
      r.clamped = 1'b1;
    end
    r.temp  = t[TEMP_W-1:0];
    r.press = p[PRESS_W-1:0];
    return r;
  endfunction

  // Smallest D2 whose first-order temperature reaches the target; clipped to
  // the raw range. With C6 = 0 the temperature is flat, so any D2 will do.
  function automatic logic [RAW_W-1:0] d2_for_temp(input coef_t k, input int signed target);
    longint num, dt, d2;
    if (k.c6 == '0) return RAW_W'($urandom);
    num = longint'(target - TEMP_REF) * TEMP_SCALE;
    if (num >= 0) dt = (num + longint'(k.c6) - 1) / longint'(k.c6);
    else dt = num / longint'(k.c6);
    d2 = longint'(k.c5) * 256 + dt;
    if (d2 < 0) d2 = 0;
    if (d2 > RAW_LIMIT) d2 = RAW_LIMIT;
    return d2[RAW_W-1:0];
  endfunction

  // Idle cycles before the next item: mostly a uniform draw, with runs of back-to-back items
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Track calibration writes the way the DUT should take them
  always @(posedge clk) begin
    if (!rst_n) begin
      coef_shadow <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_C1: coef_shadow.c1 <= cfg_data;
        CFG_C2: coef_shadow.c2 <= cfg_data;
        CFG_C3: coef_shadow.c3 <= cfg_data;
        CFG_C4: coef_shadow.c4 <= cfg_data;
        CFG_C5: coef_shadow.c5 <= cfg_data;
        CFG_C6: coef_shadow.c6 <= cfg_data;
        default: ;  // spare indexes: drop
      endcase
    end
  end

  // Driver: predict on acceptance, hold the payload while stalled, advance
  // to the next item after the drawn gap. in_valid gets at most one assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        readings_due.push_back(compensate(coef_shadow, in_raw_temperature, in_raw_pressure));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (conversions_to_send.size() > 0) begin
          next_conv = conversions_to_send.pop_front();
          in_raw_temperature <= next_conv.d2;
          in_raw_pressure    <= next_conv.d1;
          in_valid           <= 1'b1;
          in_gap = draw_wait(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction, then
  // hold off the next one for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{temp: out_temp_centi, press: out_press_centi, clamped: out_clamped};
        results_seen++;
        if (got.clamped) results_clamped++;
        if (readings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing pending: temp %0d press %0d clamped %0b",
                     $realtime, got.temp, got.press, got.clamped);
        end else begin
          want = readings_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result %0d: temp exp %0d got %0d, press exp %0d got %0d, clamped exp %0b got %0b",
                       $realtime, results_seen, want.temp, got.temp, want.press, got.press,
                       want.clamped, got.clamped);
          end
        end
        out_hold = draw_wait(out_burst);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  // Watchdog: count cycles in which no channel moves an item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no item moved for %0d cycles, %0d results outstanding",
             $realtime, WATCHDOG_LIMIT, readings_due.size());
    $display("baro_sensor_compensation verification failed");
    $finish;
  end

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Load a full calibration set; spare indexes get junk that must not land anywhere
  task automatic load_calibration(input coef_t k);
    write_coef(CFG_SPARE_LO, COEF_W'($urandom));
    write_coef(CFG_C1, k.c1);
    write_coef(CFG_C2, k.c2);
    write_coef(CFG_C3, k.c3);
    write_coef(CFG_SPARE_HI, COEF_W'($urandom));
    write_coef(CFG_C4, k.c4);
    write_coef(CFG_C5, k.c5);
    write_coef(CFG_C6, k.c6);
    cal_sets++;
  endtask

  task automatic queue_item(input logic [RAW_W-1:0] d2, input logic [RAW_W-1:0] d1);
    conversions_to_send.push_back('{d2: d2, d1: d1});
    items_queued++;
  endtask

  // Mostly temperatures steered around the working range so the cold paths
  // and the in-range pressures get hit; the rest is raw noise on all bits.
  task automatic queue_random(input coef_t k);
    logic [RAW_W-1:0] d2, d1;
    if ($urandom_range(0, 3) == 0) d2 = RAW_W'($urandom);
    else d2 = d2_for_temp(k, int'($urandom_range(0, 16000)) - 6000);
    if ($urandom_range(0, 1) == 1) d1 = RAW_W'($urandom);
    else d1 = RAW_W'($urandom_range(6000000, 11000000));
    queue_item(d2, d1);
  endtask

  // Calibration may only change with the pipe empty: every item yields one
  // result, so the last result out means nothing is left inside.
  task automatic wait_pipe_empty();
    while (items_taken != items_queued || readings_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    coef_t cal;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration (all zero): flat 20.00 C, pressure pinned to the floor
    queue_item('0, '0);
    queue_item('1, '1);
    queue_item(D2_TYPICAL, D1_TYPICAL);
    wait_pipe_empty();

    // Directed items under the typical calibration
    load_calibration(COEF_TYPICAL);
    queue_item(D2_TYPICAL, D1_TYPICAL);
    queue_item('0, '0);
    queue_item('1, '1);
    queue_item('0, '1);
    queue_item('1, '0);
    queue_item({COEF_TYPICAL.c5, 8'h00}, D1_MID);          // dT = 0
    queue_item({COEF_TYPICAL.c5, 8'h00} - 1'b1, D1_MID);   // dT = -1
    foreach (DIRECTED_TEMPS[i])
      queue_item(d2_for_temp(COEF_TYPICAL, DIRECTED_TEMPS[i]), D1_TYPICAL);
    wait_pipe_empty();

    // Corner calibrations: all ones, mixed zero/ones, minimal temperature slope
    for (int s = 0; s < 3; s++) begin
      load_calibration(EXTREME_SETS[s]);
      repeat (ITEMS_EXTREME) queue_random(EXTREME_SETS[s]);
      wait_pipe_empty();
    end

    // Random calibrations: alternate near-typical sets and fully random ones
    for (int s = 0; s < RANDOM_SETS; s++) begin
      if (s % 2 == 0) begin
        cal = COEF_TYPICAL;
        cal.c1 = cal.c1 + COEF_W'($urandom_range(0, 8191)) - 16'd4096;
        cal.c2 = cal.c2 + COEF_W'($urandom_range(0, 8191)) - 16'd4096;
        cal.c3 = cal.c3 + COEF_W'($urandom_range(0, 8191)) - 16'd4096;
        cal.c4 = cal.c4 + COEF_W'($urandom_range(0, 8191)) - 16'd4096;
        cal.c5 = cal.c5 + COEF_W'($urandom_range(0, 8191)) - 16'd4096;
        cal.c6 = cal.c6 + COEF_W'($urandom_range(0, 8191)) - 16'd4096;
      end else begin
        cal = coef_t'({$urandom, $urandom, $urandom});
      end
      load_calibration(cal);
      repeat (ITEMS_PER_SET) queue_random(cal);
      wait_pipe_empty();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d conversion pairs over %0d calibration sets plus reset values;",
             items_taken, cal_sets);
    $display("%0d results checked (%0d saturated), %0d mismatches, %0d still pending.",
             results_seen, results_clamped, mismatches, readings_due.size());
    if (mismatches == 0 && readings_due.size() == 0)
      $display("baro_sensor_compensation verification clean");
    else
      $display("baro_sensor_compensation verification failed");
    $finish;
  end

endmodule
